@@ rtl/core/hci_h4_packet_deframer_assert.svh @@
// Assertion macros for the H4 packet deframer.
`ifndef HCI_H4_PACKET_DEFRAMER_ASSERT_SVH
`define HCI_H4_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// ante holds in a cycle, cons holds in that same cycle
`define HH4D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");
// ante holds in a cycle, cons holds in the next one
`define HH4D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");
`else
`define HH4D_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HH4D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/hh4d_pkg.sv @@
// Shared types and constants of the H4 packet deframer.
package hh4d_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PAYLOAD_LEN = 1'b1;

    localparam logic [15:0] TIMEOUT_LIMIT_RST   = 16'hFFFF;
    localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd1021;
    localparam logic [15:0] IDLE_TICKS_MAX      = 16'hFFFF;

    localparam logic [2:0] ACL_HEADER_BYTES   = 3'd4;
    localparam logic [2:0] EVENT_HEADER_BYTES = 3'd2;

    localparam logic [7:0] H4_TYPE_ACL   = 8'h02;
    localparam logic [7:0] H4_TYPE_EVENT = 8'h04;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_type;
        logic       first_byte;
        logic       last_byte;
        t_status    status;
    } t_result;

endpackage

@@ rtl/core/hh4d_parser.sv @@
// Framing state machine: type hunt, header, payload, idle timeout.
module hh4d_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hh4d_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [hh4d_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_take,
    input  logic                              i_kind,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_res_valid,
    output hh4d_pkg::t_result                 o_res
);

    logic [15:0]      r_timeout_limit;
    logic [15:0]      r_max_payload_len;

    hh4d_pkg::t_phase r_phase,             n_phase;
    logic             r_type_is_event,     n_type_is_event;
    logic [2:0]       r_header_count,      n_header_count;
    logic [7:0]       r_length_low,        n_length_low;
    logic [15:0]      r_payload_remaining, n_payload_remaining;
    logic [15:0]      r_idle_ticks,        n_idle_ticks;

    logic [2:0]       w_hdr_bytes;
    logic [2:0]       w_hc_inc;
    logic [15:0]      w_len;
    logic [15:0]      w_rem_dec;
    logic [15:0]      w_idle_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit   <= hh4d_pkg::TIMEOUT_LIMIT_RST;
            r_max_payload_len <= hh4d_pkg::MAX_PAYLOAD_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hh4d_pkg::CFG_TIMEOUT_LIMIT:   r_timeout_limit   <= i_cfg_wdata;
                hh4d_pkg::CFG_MAX_PAYLOAD_LEN: r_max_payload_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= hh4d_pkg::PH_HUNT;
            r_type_is_event     <= 1'b0;
            r_header_count      <= 3'd0;
            r_length_low        <= 8'd0;
            r_payload_remaining <= 16'd0;
            r_idle_ticks        <= 16'd0;
        end else begin
            r_phase             <= n_phase;
            r_type_is_event     <= n_type_is_event;
            r_header_count      <= n_header_count;
            r_length_low        <= n_length_low;
            r_payload_remaining <= n_payload_remaining;
            r_idle_ticks        <= n_idle_ticks;
        end
    end

    assign w_hdr_bytes = r_type_is_event ? hh4d_pkg::EVENT_HEADER_BYTES
                                         : hh4d_pkg::ACL_HEADER_BYTES;
    assign w_hc_inc    = r_header_count + 3'd1;
    // event length is one byte; ACL length is little-endian over two bytes
    assign w_len       = r_type_is_event ? {8'h00, i_rx_byte} : {i_rx_byte, r_length_low};
    assign w_rem_dec   = (r_payload_remaining != 16'd0) ? r_payload_remaining - 16'd1
                                                        : 16'd0;
    assign w_idle_inc  = (r_idle_ticks != hh4d_pkg::IDLE_TICKS_MAX) ? r_idle_ticks + 16'd1
                                                                   : r_idle_ticks;

    always_comb begin
        n_phase             = r_phase;
        n_type_is_event     = r_type_is_event;
        n_header_count      = r_header_count;
        n_length_low        = r_length_low;
        n_payload_remaining = r_payload_remaining;
        n_idle_ticks        = r_idle_ticks;
        o_res_valid         = 1'b0;
        o_res.data_byte     = 8'd0;
        o_res.frame_type    = r_type_is_event;
        o_res.first_byte    = 1'b0;
        o_res.last_byte     = 1'b0;
        o_res.status        = hh4d_pkg::ST_DATA;

        if (i_take) begin
            if (i_kind == hh4d_pkg::KIND_IDLE) begin
                if (r_phase != hh4d_pkg::PH_HUNT) begin
                    n_idle_ticks = w_idle_inc;
                    if (w_idle_inc >= r_timeout_limit) begin
                        o_res_valid  = 1'b1;
                        o_res.status = hh4d_pkg::ST_TIMEOUT;
                        n_phase      = hh4d_pkg::PH_HUNT;
                    end
                end
            end else begin
                unique case (r_phase)
                    hh4d_pkg::PH_HEADER: begin
                        if (!r_type_is_event && r_header_count == (w_hdr_bytes - 3'd2)) begin
                            n_length_low = i_rx_byte;
                        end
                        n_header_count = w_hc_inc;
                        o_res_valid    = 1'b1;
                        if (w_hc_inc < w_hdr_bytes) begin
                            o_res.data_byte  = i_rx_byte;
                            o_res.first_byte = (r_header_count == 3'd0);
                        end else begin
                            n_idle_ticks = 16'd0;
                            if (w_len > r_max_payload_len) begin
                                o_res.status = hh4d_pkg::ST_TOO_LONG;
                                n_phase      = hh4d_pkg::PH_HUNT;
                            end else begin
                                o_res.data_byte  = i_rx_byte;
                                o_res.first_byte = (r_header_count == 3'd0);
                                if (w_len == 16'd0) begin
                                    o_res.last_byte = 1'b1;
                                    n_phase         = hh4d_pkg::PH_HUNT;
                                end else begin
                                    n_payload_remaining = w_len;
                                    n_phase             = hh4d_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    hh4d_pkg::PH_PAYLOAD: begin
                        n_payload_remaining = w_rem_dec;
                        o_res_valid         = 1'b1;
                        o_res.data_byte     = i_rx_byte;
                        if (w_rem_dec == 16'd0) begin
                            o_res.last_byte = 1'b1;
                            n_phase         = hh4d_pkg::PH_HUNT;
                        end
                    end
                    default: begin
                        // hunting: drop everything but a known type byte
                        n_phase = hh4d_pkg::PH_HUNT;
                        if (i_rx_byte == hh4d_pkg::H4_TYPE_ACL ||
                            i_rx_byte == hh4d_pkg::H4_TYPE_EVENT) begin
                            n_type_is_event     = (i_rx_byte == hh4d_pkg::H4_TYPE_EVENT);
                            n_header_count      = 3'd0;
                            n_length_low        = 8'd0;
                            n_payload_remaining = 16'd0;
                            n_idle_ticks        = 16'd0;
                            n_phase             = hh4d_pkg::PH_HEADER;
                        end
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/core/hh4d_out_buf.sv @@
// Result register with one skid entry behind it.
module hh4d_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hh4d_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output hh4d_pkg::t_result o_res,
    output logic              o_full
);

    logic              r_main_valid, n_main_valid;
    logic              r_skid_valid, n_skid_valid;
    hh4d_pkg::t_result r_main,       n_main;
    hh4d_pkg::t_result r_skid,       n_skid;
    logic              w_slot_free;

    assign w_slot_free = !r_main_valid || !i_stall;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_slot_free) begin
            if (r_skid_valid) begin
                // skid full means no push this cycle
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_res;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    assign o_full  = r_skid_valid;

endmodule

@@ rtl/core/hci_h4_packet_deframer.sv @@
// H4 packet deframer top level: parser plus output buffering.
//
// Input channel (i_in_valid / o_in_stall): one request per cycle, either a
// received UART byte (i_kind = 0, i_rx_byte) or an idle tick (i_kind = 1).
// Output channel (o_out_valid / i_out_stall): header and payload bytes with
// packet type and first/last marks, or an abort record (o_status 1 = idle
// timeout, 2 = length above the limit).
// Config: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
// (0 = timeout_limit, 1 = max_payload_len); write only while idle.
// Each result is registered in the result register, or in the skid entry.
// Throughput: one request per cycle if not stalled; the whole state update
// is a single combinational pass from the request into the result register.
// Stall: a held result keeps its register; one more result goes into a skid
// entry, and o_in_stall is high while that entry is occupied.
// Reset (synchronous, active low): hunting for a type byte, no result held,
// timeout_limit = 65535, max_payload_len = 1021.
`include "hci_h4_packet_deframer_assert.svh"
module hci_h4_packet_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hh4d_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [hh4d_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_data_byte,
    output logic                            o_frame_type,
    output logic                            o_first_byte,
    output logic                            o_last_byte,
    output logic [1:0]                      o_status
);

    logic              w_take;
    logic              w_res_valid;
    logic              w_full;
    hh4d_pkg::t_result w_res;
    hh4d_pkg::t_result w_out;

    assign w_take     = i_in_valid && !w_full;
    assign o_in_stall = w_full;

    hh4d_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_kind      (i_kind),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    hh4d_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (w_out),
        .o_full  (w_full)
    );

    assign o_data_byte  = w_out.data_byte;
    assign o_frame_type = w_out.frame_type;
    assign o_first_byte = w_out.first_byte;
    assign o_last_byte  = w_out.last_byte;
    assign o_status     = w_out.status;

    // skid entry only fills behind a held result
    `HH4D_ASSERT_SAME(a_skid_behind_main, i_clk, i_rst_n, o_in_stall, o_out_valid)
    // abort records carry no byte and no marks
    `HH4D_ASSERT_SAME(a_abort_clean, i_clk, i_rst_n,
        o_out_valid && o_status != hh4d_pkg::ST_DATA,
        o_data_byte == 8'd0 && !o_first_byte && !o_last_byte)
    // a packet byte is never both first and last
    `HH4D_ASSERT_SAME(a_first_not_last, i_clk, i_rst_n, o_out_valid,
        !(o_first_byte && o_last_byte))
    // a full skid entry takes no request, so it moves up next cycle if drained
    `HH4D_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, o_in_stall && !i_out_stall,
        o_out_valid && !o_in_stall)

endmodule
